/* rtl/ppt_pkg.sv */
// Shared constants, types and tables of the pure pursuit path tracker.
package ppt_pkg;

  localparam int PATH_DEPTH   = 1024;
  localparam int CORDIC_STEPS = 16;
  localparam int ADDR_W       = $clog2(PATH_DEPTH);
  localparam int CNT_W        = $clog2(PATH_DEPTH + 1);
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

  // One store entry: x, y and speed side by side.
  localparam int ENTRY_W = 80;

  // Wheel division: numerator, divisor and quotient widths.
  localparam int NUM_W  = 80;
  localparam int DEN_W  = 64;
  localparam int QUO_W  = 16;
  localparam int QCNT_W = $clog2(QUO_W + 1);

  localparam logic signed [33:0] GAIN_INV = 34'sd652032874;

  localparam logic       OP_LOAD = 1'b0;
  localparam logic       OP_POSE = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [1:0] CFG_LOOKAHEAD = 2'd0;
  localparam logic [1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [1:0] CFG_SPEED_LIM = 2'd2;
  localparam logic [1:0] CFG_TRACK     = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EXT_SQ, ST_EXT_CMP, ST_CORDIC, ST_PROJ, ST_SCAN_G, ST_SCAN_R,
    ST_SCAN_END, ST_FETCH_G, ST_FETCH_R, ST_SPEED, ST_SIDE, ST_SQUARE, ST_KMUL,
    ST_NUMER, ST_MUL_VM, ST_MUL_SD, ST_SCALE, ST_MUL_L, ST_DIVL_GO, ST_DIVL,
    ST_MUL_R, ST_DIVR_GO, ST_DIVR, ST_ARRIVE, ST_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Arc tangent of 2^-i as a binary angle, 2^32 per turn.
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      5'd31: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

/* rtl/pure_pursuit_path_tracker.sv */
// Top level of the pure pursuit path tracker: sequencer and datapath.
//
// Requests enter on start_i with the payload ports and are taken at a rising
// edge where start_i is high and busy_o is low. Each request gives exactly one
// result, shown for one cycle on the result ports with done_o high; the
// receiver cannot stall, so the result is taken in that cycle.
// Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; cfg_ready_o is always high. Write only while busy_o is low.
//
// A load goes straight from request to result; a final point first appends
// points along its last segment until their offset reaches twice the lookahead
// or the store is full. A pose step runs 16 CORDIC steps, a scan of the store
// through its single read port, and two wheel divisions of 16 quotient bits.
// An empty-path pose step or a load into a full store goes right to the result.
// A new request is taken in the cycle its predecessor's result is shown.
//
// Reset empties the path, clears the end and previous points and loads the
// default register values; store contents are undefined until written.
module pure_pursuit_path_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               op_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [15:0] point_speed_i,
  input  logic [15:0]        heading_angle_i,
  input  logic               final_point_i,
  output logic               done_o,
  output logic signed [15:0] left_drive_o,
  output logic signed [15:0] right_drive_o,
  output logic               arrived_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  localparam logic signed [32:0] SAT_P = 33'sd1073741824;
  localparam logic signed [32:0] SAT_N = -33'sd1073741824;
  localparam logic signed [32:0] QTURN = 33'sd1073741824;
  localparam logic signed [32:0] HTURN = 33'sd2147483648;

  ppt_pkg::state_e state_q, state_d;

  // Control and architectural state.
  logic [ppt_pkg::CNT_W-1:0] count_q;
  logic signed [31:0]        end_x_q, end_y_q, prev_x_q, prev_y_q;
  logic [23:0]               look_q, tol_q, track_q;
  logic [14:0]               slim_q;
  logic                      done_q, done_d;

  // Datapath registers.
  logic signed [31:0]  x_q, y_q;
  logic signed [15:0]  speed_q;
  logic                op_q;
  logic [1:0]          status_q;
  logic signed [15:0]  left_q, right_q;
  logic                arrived_q;
  logic signed [33:0]  ddx_q, ddy_q;
  logic signed [44:0]  ox_q, oy_q;
  logic                ext_big_q;
  logic [49:0]         ext_sqx_q, ext_sqy_q, ext_lim_q;
  logic signed [32:0]  z_q;
  logic                flip_q;
  logic signed [33:0]  cx_q, cy_q;
  logic [ppt_pkg::STEP_W-1:0] step_q;
  logic signed [34:0]  gx_q, gy_q;
  logic [ppt_pkg::CNT_W-1:0]  idx_q;
  logic [69:0]         sq_x_q, sq_y_q;
  logic                sq_goal_q, sq_vld_q;
  logic [ppt_pkg::ADDR_W-1:0] sq_idx_q, bidx_g_q, bidx_r_q;
  logic [71:0]         best_g_q, best_r_q;
  logic signed [31:0]  dx_q, dy_q;
  logic signed [15:0]  v_q;
  logic signed [59:0]  p1_q, p2_q;
  logic signed [35:0]  side_q;
  logic [61:0]         sqdx_q, sqdy_q;
  logic [63:0]         d2_q, m_q;
  logic signed [63:0]  k_q, nl_q, nr_q;
  logic [79:0]         mul_q, h1_q;
  logic                scale_q;
  logic                arr_big_q;
  logic [47:0]         ex2_q, ey2_q, tol2_q;

  ppt_pkg::mem_ctl_t            mem_ctl;
  logic [ppt_pkg::ENTRY_W-1:0]  mem_wdata, mem_rdata;
  logic                         div_start;
  logic [ppt_pkg::QUO_W-1:0]    div_quo;
  ppt_pkg::div_stat_t           div_stat;

  logic accept, full, last_step, scan_more, ext_stop;

  ppt_path_mem u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  ppt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_q),
    .den_i   (scale_q ? m_q : d2_q),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  assign accept      = start_i && (state_q == ppt_pkg::ST_IDLE);
  assign full        = count_q >= ppt_pkg::CNT_W'(ppt_pkg::PATH_DEPTH);
  assign last_step   = step_q == ppt_pkg::STEP_W'(ppt_pkg::CORDIC_STEPS - 1);
  assign scan_more   = (idx_q + ppt_pkg::CNT_W'(1)) < count_q;
  assign ext_stop    = ext_big_q ||
                       (({1'b0, ext_sqx_q} + {1'b0, ext_sqy_q}) >= {1'b0, ext_lim_q});
  assign busy_o      = state_q != ppt_pkg::ST_IDLE;
  assign cfg_ready_o = 1'b1;

  // ---------------- Combinational datapath pieces ----------------

  // Store read data fields.
  logic signed [31:0] rd_x, rd_y;
  logic signed [15:0] rd_s;
  assign rd_x = $signed(mem_rdata[79:48]);
  assign rd_y = $signed(mem_rdata[47:16]);
  assign rd_s = $signed(mem_rdata[15:0]);

  // Extension step.
  logic signed [44:0] ox_n, oy_n;
  logic [44:0]        omx, omy;
  logic [24:0]        look2;
  assign ox_n  = ox_q + 45'(ddx_q);
  assign oy_n  = oy_q + 45'(ddy_q);
  assign omx   = ox_q[44] ? 45'(-ox_q) : 45'(ox_q);
  assign omy   = oy_q[44] ? 45'(-oy_q) : 45'(oy_q);
  assign look2 = {look_q, 1'b0};

  // Heading fold into the right half plane.
  logic signed [32:0] z_raw, z_init;
  logic               flip_init;
  always_comb begin
    z_raw     = 33'($signed({heading_angle_i, 16'h0000}));
    z_init    = z_raw;
    flip_init = 1'b0;
    if (z_raw > QTURN) begin
      z_init    = z_raw - HTURN;
      flip_init = 1'b1;
    end else if (z_raw < -QTURN) begin
      z_init    = z_raw + HTURN;
      flip_init = 1'b1;
    end
  end

  // One CORDIC rotation.
  logic signed [33:0] cx_sh, cy_sh, cx_n, cy_n;
  logic signed [32:0] z_n, atan_s;
  always_comb begin
    cx_sh  = cx_q >>> step_q;
    cy_sh  = cy_q >>> step_q;
    atan_s = $signed({1'b0, ppt_pkg::atan_q30(5'(step_q))});
    if (!z_q[32]) begin
      cx_n = cx_q - cy_sh;
      cy_n = cy_q + cx_sh;
      z_n  = z_q - atan_s;
    end else begin
      cx_n = cx_q + cy_sh;
      cy_n = cy_q - cx_sh;
      z_n  = z_q + atan_s;
    end
  end

  // Lookahead projection.
  logic signed [33:0] cxf, cyf;
  logic signed [58:0] lmx, lmy;
  logic signed [34:0] gx_n, gy_n;
  assign cxf  = flip_q ? -cx_q : cx_q;
  assign cyf  = flip_q ? -cy_q : cy_q;
  assign lmx  = $signed({1'b0, look_q}) * cxf;
  assign lmy  = $signed({1'b0, look_q}) * cyf;
  assign gx_n = 35'(x_q) + 35'(lmx >>> 30);
  assign gy_n = 35'(y_q) + 35'(lmy >>> 30);

  // Squared distance of the read entry to the goal or the robot.
  logic signed [34:0] tx, ty, sdx, sdy;
  logic [34:0]        smx, smy;
  logic [69:0]        sqx_n, sqy_n;
  logic [70:0]        sq_sum;
  always_comb begin
    if (state_q == ppt_pkg::ST_SCAN_G) begin
      tx = gx_q;
      ty = gy_q;
    end else begin
      tx = 35'(x_q);
      ty = 35'(y_q);
    end
    sdx    = 35'(rd_x) - tx;
    sdy    = 35'(rd_y) - ty;
    smx    = sdx[34] ? 35'(-sdx) : 35'(sdx);
    smy    = sdy[34] ? 35'(-sdy) : 35'(sdy);
    sqx_n  = smx * smx;
    sqy_n  = smy * smy;
    sq_sum = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  end

  // Goal offset, saturated.
  logic signed [32:0] gdx, gdy;
  logic signed [31:0] gdx_s, gdy_s;
  always_comb begin
    gdx = 33'(rd_x) - 33'(x_q);
    gdy = 33'(rd_y) - 33'(y_q);
    if (gdx > SAT_P)      gdx_s = 32'(SAT_P);
    else if (gdx < SAT_N) gdx_s = 32'(SAT_N);
    else                  gdx_s = gdx[31:0];
    if (gdy > SAT_P)      gdy_s = 32'(SAT_P);
    else if (gdy < SAT_N) gdy_s = 32'(SAT_N);
    else                  gdy_s = gdy[31:0];
  end

  // Curvature and wheel terms.
  logic signed [27:0] cxs, cys;
  logic signed [59:0] p1_n, p2_n;
  logic signed [60:0] pdiff;
  logic [30:0]        mdx, mdy;
  logic signed [60:0] k_n;
  logic               d2_zero;
  logic [63:0]        d2e, mnl, mnr;
  logic signed [63:0] ke, nl_n, nr_n;
  logic [15:0]        absv, slim16, mul_a;
  logic [63:0]        mul_b;
  always_comb begin
    cxs     = 28'(cx_q >>> 6);
    cys     = 28'(cy_q >>> 6);
    p1_n    = dx_q * cys;
    p2_n    = dy_q * cxs;
    pdiff   = 61'(p1_q) - 61'(p2_q);
    mdx     = dx_q[31] ? 31'(-dx_q) : 31'(dx_q);
    mdy     = dy_q[31] ? 31'(-dy_q) : 31'(dy_q);
    k_n     = side_q * $signed({1'b0, track_q});
    d2_zero = d2_q == '0;
    d2e     = d2_zero ? 64'd1 : d2_q;
    ke      = d2_zero ? 64'sd0 : k_q;
    nl_n    = $signed(d2e) + ke;
    nr_n    = $signed(d2e) - ke;
    mnl     = nl_n[63] ? 64'(-nl_n) : 64'(nl_n);
    mnr     = nr_n[63] ? 64'(-nr_n) : 64'(nr_n);
    absv    = v_q[15] ? 16'(-v_q) : 16'(v_q);
    slim16  = {1'b0, slim_q};
    unique case (state_q)
      ppt_pkg::ST_MUL_VM: begin
        mul_a = absv;
        mul_b = m_q;
      end
      ppt_pkg::ST_MUL_SD: begin
        mul_a = slim16;
        mul_b = d2_q;
      end
      ppt_pkg::ST_MUL_L: begin
        mul_a = scale_q ? slim16 : absv;
        mul_b = nl_q[63] ? 64'(-nl_q) : 64'(nl_q);
      end
      default: begin
        mul_a = scale_q ? slim16 : absv;
        mul_b = nr_q[63] ? 64'(-nr_q) : 64'(nr_q);
      end
    endcase
  end

  logic [79:0] mul_n;
  assign mul_n = mul_a * mul_b;

  // Signed wheel value from the unsigned quotient.
  logic signed [15:0] wheel_l, wheel_r;
  assign wheel_l = (v_q[15] ^ nl_q[63]) ? 16'(-div_quo) : 16'(div_quo);
  assign wheel_r = (v_q[15] ^ nr_q[63]) ? 16'(-div_quo) : 16'(div_quo);

  // Distance to the original end point.
  logic signed [32:0] ex, ey;
  logic [32:0]        emx, emy;
  assign ex  = 33'(x_q) - 33'(end_x_q);
  assign ey  = 33'(y_q) - 33'(end_y_q);
  assign emx = ex[32] ? 33'(-ex) : 33'(ex);
  assign emy = ey[32] ? 33'(-ey) : 33'(ey);

  // ---------------- Sequencer ----------------

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppt_pkg::ST_IDLE: begin
        if (accept) begin
          if (op_i == ppt_pkg::OP_LOAD) begin
            if (!full && final_point_i) state_d = ppt_pkg::ST_EXT_SQ;
            else                        state_d = ppt_pkg::ST_DONE;
          end else if (count_q == '0) begin
            state_d = ppt_pkg::ST_DONE;
          end else begin
            state_d = ppt_pkg::ST_CORDIC;
          end
        end
      end
      ppt_pkg::ST_EXT_SQ:   state_d = full ? ppt_pkg::ST_DONE : ppt_pkg::ST_EXT_CMP;
      ppt_pkg::ST_EXT_CMP:  state_d = ext_stop ? ppt_pkg::ST_DONE : ppt_pkg::ST_EXT_SQ;
      ppt_pkg::ST_CORDIC:   if (last_step) state_d = ppt_pkg::ST_PROJ;
      ppt_pkg::ST_PROJ:     state_d = ppt_pkg::ST_SCAN_G;
      ppt_pkg::ST_SCAN_G:   state_d = ppt_pkg::ST_SCAN_R;
      ppt_pkg::ST_SCAN_R:   state_d = scan_more ? ppt_pkg::ST_SCAN_G : ppt_pkg::ST_SCAN_END;
      ppt_pkg::ST_SCAN_END: state_d = ppt_pkg::ST_FETCH_G;
      ppt_pkg::ST_FETCH_G:  state_d = ppt_pkg::ST_FETCH_R;
      ppt_pkg::ST_FETCH_R:  state_d = ppt_pkg::ST_SPEED;
      ppt_pkg::ST_SPEED:    state_d = ppt_pkg::ST_SIDE;
      ppt_pkg::ST_SIDE:     state_d = ppt_pkg::ST_SQUARE;
      ppt_pkg::ST_SQUARE:   state_d = ppt_pkg::ST_KMUL;
      ppt_pkg::ST_KMUL:     state_d = ppt_pkg::ST_NUMER;
      ppt_pkg::ST_NUMER:    state_d = ppt_pkg::ST_MUL_VM;
      ppt_pkg::ST_MUL_VM:   state_d = ppt_pkg::ST_MUL_SD;
      ppt_pkg::ST_MUL_SD:   state_d = ppt_pkg::ST_SCALE;
      ppt_pkg::ST_SCALE:    state_d = ppt_pkg::ST_MUL_L;
      ppt_pkg::ST_MUL_L:    state_d = ppt_pkg::ST_DIVL_GO;
      ppt_pkg::ST_DIVL_GO:  state_d = ppt_pkg::ST_DIVL;
      ppt_pkg::ST_DIVL:     if (div_stat.done) state_d = ppt_pkg::ST_MUL_R;
      ppt_pkg::ST_MUL_R:    state_d = ppt_pkg::ST_DIVR_GO;
      ppt_pkg::ST_DIVR_GO:  state_d = ppt_pkg::ST_DIVR;
      ppt_pkg::ST_DIVR:     if (div_stat.done) state_d = ppt_pkg::ST_ARRIVE;
      ppt_pkg::ST_ARRIVE:   state_d = ppt_pkg::ST_DONE;
      ppt_pkg::ST_DONE:     state_d = ppt_pkg::ST_IDLE;
      default:              state_d = ppt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl   = '0;
    mem_wdata = {coord_x_i, coord_y_i, point_speed_i};
    div_start = 1'b0;
    done_d    = 1'b0;
    unique case (state_q)
      ppt_pkg::ST_IDLE: begin
        mem_ctl.we    = accept && (op_i == ppt_pkg::OP_LOAD) && !full;
        mem_ctl.waddr = count_q[ppt_pkg::ADDR_W-1:0];
      end
      ppt_pkg::ST_EXT_CMP: begin
        mem_ctl.we    = !ext_stop;
        mem_ctl.waddr = count_q[ppt_pkg::ADDR_W-1:0];
        mem_wdata     = {x_q + ox_n[31:0], y_q + oy_n[31:0], speed_q};
      end
      ppt_pkg::ST_PROJ: begin
        mem_ctl.re    = 1'b1;
        mem_ctl.raddr = '0;
      end
      ppt_pkg::ST_SCAN_R: begin
        mem_ctl.re    = scan_more;
        mem_ctl.raddr = ppt_pkg::ADDR_W'(idx_q + ppt_pkg::CNT_W'(1));
      end
      ppt_pkg::ST_FETCH_G: begin
        mem_ctl.re    = 1'b1;
        mem_ctl.raddr = bidx_g_q;
      end
      ppt_pkg::ST_FETCH_R: begin
        mem_ctl.re    = 1'b1;
        mem_ctl.raddr = bidx_r_q;
      end
      ppt_pkg::ST_DIVL_GO, ppt_pkg::ST_DIVR_GO: div_start = 1'b1;
      ppt_pkg::ST_DONE:                          done_d    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ppt_pkg::ST_IDLE;
      count_q  <= '0;
      end_x_q  <= '0;
      end_y_q  <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      look_q   <= 24'd786432;
      tol_q    <= 24'd131072;
      slim_q   <= 15'd127;
      track_q  <= 24'd786432;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (mem_ctl.we) begin
        count_q <= count_q + ppt_pkg::CNT_W'(1);
      end
      if (accept && (op_i == ppt_pkg::OP_LOAD) && !full) begin
        prev_x_q <= coord_x_i;
        prev_y_q <= coord_y_i;
        if (final_point_i) begin
          end_x_q <= coord_x_i;
          end_y_q <= coord_y_i;
        end
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ppt_pkg::CFG_LOOKAHEAD: look_q  <= cfg_data_i;
          ppt_pkg::CFG_TOLERANCE: tol_q   <= cfg_data_i;
          ppt_pkg::CFG_SPEED_LIM: slim_q  <= cfg_data_i[14:0];
          ppt_pkg::CFG_TRACK:     track_q <= cfg_data_i;
        endcase
      end
    end
  end

  // ---------------- Datapath registers ----------------

  always_ff @(posedge clk_i) begin
    // Running minimum over the scan; strict compare keeps the lowest index.
    if (sq_vld_q) begin
      if (sq_goal_q) begin
        if ({1'b0, sq_sum} < best_g_q) begin
          best_g_q <= {1'b0, sq_sum};
          bidx_g_q <= sq_idx_q;
        end
      end else if ({1'b0, sq_sum} < best_r_q) begin
        best_r_q <= {1'b0, sq_sum};
        bidx_r_q <= sq_idx_q;
      end
    end

    unique case (state_q)
      ppt_pkg::ST_IDLE: begin
        if (accept) begin
          x_q       <= coord_x_i;
          y_q       <= coord_y_i;
          speed_q   <= point_speed_i;
          op_q      <= op_i;
          left_q    <= '0;
          right_q   <= '0;
          arrived_q <= 1'b0;
          ddx_q     <= 34'(coord_x_i) - 34'(prev_x_q);
          ddy_q     <= 34'(coord_y_i) - 34'(prev_y_q);
          ox_q      <= '0;
          oy_q      <= '0;
          z_q       <= z_init;
          flip_q    <= flip_init;
          cx_q      <= ppt_pkg::GAIN_INV;
          cy_q      <= '0;
          step_q    <= '0;
          if (op_i == ppt_pkg::OP_LOAD) begin
            status_q <= full ? ppt_pkg::STAT_FULL : ppt_pkg::STAT_OK;
          end else begin
            status_q <= (count_q == '0) ? ppt_pkg::STAT_EMPTY : ppt_pkg::STAT_OK;
          end
        end
      end
      ppt_pkg::ST_EXT_SQ: begin
        // An offset of 2^25 or more already passes any lookahead limit.
        ext_big_q <= (omx[44:25] != '0) || (omy[44:25] != '0);
        ext_sqx_q <= omx[24:0] * omx[24:0];
        ext_sqy_q <= omy[24:0] * omy[24:0];
        ext_lim_q <= look2 * look2;
      end
      ppt_pkg::ST_EXT_CMP: begin
        if (!ext_stop) begin
          ox_q <= ox_n;
          oy_q <= oy_n;
        end
      end
      ppt_pkg::ST_CORDIC: begin
        cx_q   <= cx_n;
        cy_q   <= cy_n;
        z_q    <= z_n;
        step_q <= step_q + ppt_pkg::STEP_W'(1);
      end
      ppt_pkg::ST_PROJ: begin
        cx_q     <= cxf;
        cy_q     <= cyf;
        gx_q     <= gx_n;
        gy_q     <= gy_n;
        idx_q    <= '0;
        best_g_q <= '1;
        best_r_q <= '1;
        sq_vld_q <= 1'b0;
      end
      ppt_pkg::ST_SCAN_G, ppt_pkg::ST_SCAN_R: begin
        sq_x_q    <= sqx_n;
        sq_y_q    <= sqy_n;
        sq_goal_q <= state_q == ppt_pkg::ST_SCAN_G;
        sq_idx_q  <= idx_q[ppt_pkg::ADDR_W-1:0];
        sq_vld_q  <= 1'b1;
        if (state_q == ppt_pkg::ST_SCAN_R && scan_more) begin
          idx_q <= idx_q + ppt_pkg::CNT_W'(1);
        end
      end
      ppt_pkg::ST_SCAN_END: sq_vld_q <= 1'b0;
      ppt_pkg::ST_FETCH_R: begin
        dx_q <= gdx_s;
        dy_q <= gdy_s;
      end
      ppt_pkg::ST_SPEED: v_q <= rd_s;
      ppt_pkg::ST_SIDE: begin
        p1_q <= p1_n;
        p2_q <= p2_n;
      end
      ppt_pkg::ST_SQUARE: begin
        side_q <= 36'(pdiff >>> 24);
        sqdx_q <= mdx * mdx;
        sqdy_q <= mdy * mdy;
      end
      ppt_pkg::ST_KMUL: begin
        d2_q <= 64'(sqdx_q) + 64'(sqdy_q);
        k_q  <= 64'(k_n);
      end
      ppt_pkg::ST_NUMER: begin
        // A goal on the robot gives zero curvature.
        d2_q <= d2e;
        nl_q <= nl_n;
        nr_q <= nr_n;
        m_q  <= (mnl > mnr) ? mnl : mnr;
      end
      ppt_pkg::ST_MUL_VM: mul_q <= mul_n;
      ppt_pkg::ST_MUL_SD: begin
        h1_q  <= mul_q;
        mul_q <= mul_n;
      end
      ppt_pkg::ST_SCALE:  scale_q <= h1_q > mul_q;
      ppt_pkg::ST_MUL_L, ppt_pkg::ST_MUL_R: mul_q <= mul_n;
      ppt_pkg::ST_DIVL: if (div_stat.done) left_q <= wheel_l;
      ppt_pkg::ST_DIVR: if (div_stat.done) right_q <= wheel_r;
      ppt_pkg::ST_ARRIVE: begin
        // Beyond 2^24 on either axis the tolerance can never be met.
        arr_big_q <= (emx[32:24] != '0) || (emy[32:24] != '0);
        ex2_q     <= emx[23:0] * emx[23:0];
        ey2_q     <= emy[23:0] * emy[23:0];
        tol2_q    <= tol_q * tol_q;
      end
      ppt_pkg::ST_DONE: begin
        if (op_q == ppt_pkg::OP_POSE && status_q == ppt_pkg::STAT_OK) begin
          arrived_q <= !arr_big_q &&
                       (({1'b0, ex2_q} + {1'b0, ey2_q}) < {1'b0, tol2_q});
        end
      end
      default: ;
    endcase
  end

  assign done_o        = done_q;
  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign arrived_o     = arrived_q;
  assign status_o      = status_q;

endmodule

/* rtl/ppt_path_mem.sv */
// Path point store: one write port and one registered read port.
module ppt_path_mem (
  input  logic                      clk_i,
  input  ppt_pkg::mem_ctl_t         ctl_i,
  input  logic [ppt_pkg::ENTRY_W-1:0] wdata_i,
  output logic [ppt_pkg::ENTRY_W-1:0] rdata_o
);

  logic [ppt_pkg::ENTRY_W-1:0] mem_q [ppt_pkg::PATH_DEPTH];
  logic [ppt_pkg::ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[ctl_i.waddr] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[ctl_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ppt_div.sv */
// Restoring divider, one quotient bit per cycle, for quotients below 2^16.
module ppt_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ppt_pkg::NUM_W-1:0] num_i,
  input  logic [ppt_pkg::DEN_W-1:0] den_i,
  output logic [ppt_pkg::QUO_W-1:0] quo_o,
  output ppt_pkg::div_stat_t        stat_o
);

  logic [ppt_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                       done_q, done_d;
  logic [ppt_pkg::NUM_W-1:0]  rem_q, dsh_q;
  logic [ppt_pkg::QUO_W-1:0]  quo_q;
  logic                       fits;

  assign fits = rem_q >= dsh_q;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = ppt_pkg::QCNT_W'(ppt_pkg::QUO_W);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - ppt_pkg::QCNT_W'(1);
      done_d = (cnt_q == ppt_pkg::QCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // The divisor starts shifted up by the top quotient bit and walks down.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= ppt_pkg::NUM_W'({den_i, {ppt_pkg::QUO_W{1'b0}}} >> 1);
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[ppt_pkg::QUO_W-2:0], fits};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = cnt_q != '0;
  assign stat_o.done = done_q;

endmodule

/* rtl/ppt_checker.sv */
// Port-level checks of the path tracker, bound to the top level.
module ppt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic signed [15:0] left_drive_o,
  input logic signed [15:0] right_drive_o,
  input logic               arrived_o,
  input logic [1:0]         status_o
);

  // A taken request keeps the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o low after a request was taken");

  // Results never come in two adjacent cycles.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in adjacent cycles");

  // A result shows only while the block is ready for the next request.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // Error results carry zero drives and no arrival.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ppt_pkg::STAT_OK) |->
      (left_drive_o == 16'sd0 && right_drive_o == 16'sd0 && !arrived_o))
    else $error("error result with nonzero fields");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ppt_pkg::STAT_OK || status_o == ppt_pkg::STAT_FULL ||
                status_o == ppt_pkg::STAT_EMPTY))
    else $error("undefined status code");

endmodule

bind pure_pursuit_path_tracker ppt_checker u_ppt_checker (.*);

/* dv/pure_pursuit_path_tracker_test.sv */
// Self-checking testbench of the pure pursuit path tracker.
module pure_pursuit_path_tracker_test;

  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 118;
  localparam longint ARC_TAB [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               arrived;
    logic [1:0]         status;
  } drive_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               op_i = ppt_pkg::OP_LOAD;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic signed [15:0] point_speed_i = '0;
  logic [15:0]        heading_angle_i = '0;
  logic               final_point_i = 1'b0;
  logic               done_o;
  logic signed [15:0] left_drive_o;
  logic signed [15:0] right_drive_o;
  logic               arrived_o;
  logic [1:0]         status_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = ppt_pkg::CFG_LOOKAHEAD;
  logic [23:0]        cfg_data_i = '0;

  pure_pursuit_path_tracker uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tracker copy: path store, end and previous points, registers.
  logic signed [31:0] trk_x [ppt_pkg::PATH_DEPTH];
  logic signed [31:0] trk_y [ppt_pkg::PATH_DEPTH];
  logic signed [15:0] trk_speed [ppt_pkg::PATH_DEPTH];
  int unsigned        trk_count = 0;
  longint             trk_end_x = 0, trk_end_y = 0, trk_prev_x = 0, trk_prev_y = 0;
  logic [63:0]        reg_lookahead = 64'd786432;
  logic [63:0]        reg_tolerance = 64'd131072;
  logic [63:0]        reg_speed_lim = 64'd127;
  logic [63:0]        reg_track = 64'd786432;

  drive_result_t expected_drives [$];
  int mismatches = 0;
  int burst_left = 0;
  bit no_idle = 0;

  function automatic logic [63:0] magnitude(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic [127:0] wide(logic [63:0] a);
    return {64'b0, a};
  endfunction

  function automatic logic [127:0] dist_sq(longint a, longint b);
    return wide(magnitude(a)) * wide(magnitude(a)) + wide(magnitude(b)) * wide(magnitude(b));
  endfunction

  function automatic int unsigned nearest_point(longint px, longint py);
    int unsigned best;
    logic [127:0] best_d, d;
    best = 0;
    best_d = dist_sq(longint'(trk_x[0]) - px, longint'(trk_y[0]) - py);
    for (int unsigned i = 1; i < trk_count; i++) begin
      d = dist_sq(longint'(trk_x[i]) - px, longint'(trk_y[i]) - py);
      if (d < best_d) begin
        best = i;
        best_d = d;
      end
    end
    return best;
  endfunction

  function automatic longint clamp_offset(longint a);
    if (a > 64'sd1073741824) return 64'sd1073741824;
    if (a < -64'sd1073741824) return -64'sd1073741824;
    return a;
  endfunction

  function automatic longint wheel_drive(longint v, longint num, logic [63:0] d2,
                                         logic [63:0] m, bit scaled);
    logic [127:0] q;
    if (scaled) q = wide(reg_speed_lim) * wide(magnitude(num)) / wide(m);
    else q = wide(magnitude(v)) * wide(magnitude(num)) / wide(d2);
    return ((v < 0) != (num < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  task automatic track_request(logic op, logic signed [31:0] cx_in, logic signed [31:0] cy_in,
                               logic signed [15:0] spd, logic [15:0] hd, logic fin);
    drive_result_t r;
    longint x, y, ddx, ddy, ox, oy, cx, cy, z, t, dx, dy, side, k, nl, nr, v;
    logic [63:0] d2, m, two_l;
    logic [127:0] lim;
    bit flip;
    int unsigned g;
    x = longint'(cx_in);
    y = longint'(cy_in);
    r = '{left: '0, right: '0, arrived: 1'b0, status: ppt_pkg::STAT_OK};
    if (op == ppt_pkg::OP_LOAD) begin
      if (trk_count >= ppt_pkg::PATH_DEPTH) begin
        r.status = ppt_pkg::STAT_FULL;
      end else begin
        trk_x[trk_count] = cx_in;
        trk_y[trk_count] = cy_in;
        trk_speed[trk_count] = spd;
        trk_count++;
        if (fin) begin
          ddx = x - trk_prev_x;
          ddy = y - trk_prev_y;
          ox = 0;
          oy = 0;
          two_l = 2 * reg_lookahead;
          lim = wide(two_l) * wide(two_l);
          trk_end_x = x;
          trk_end_y = y;
          while (trk_count < ppt_pkg::PATH_DEPTH) begin
            if (dist_sq(ox, oy) >= lim) break;
            ox += ddx;
            oy += ddy;
            trk_x[trk_count] = 32'(x + ox);
            trk_y[trk_count] = 32'(y + oy);
            trk_speed[trk_count] = spd;
            trk_count++;
          end
        end
        trk_prev_x = x;
        trk_prev_y = y;
      end
    end else if (trk_count == 0) begin
      r.status = ppt_pkg::STAT_EMPTY;
    end else begin
      // Heading as cos/sin in Q2.30; the outer half turn is folded first.
      cx = 64'sd652032874;
      cy = 0;
      flip = 0;
      z = longint'($signed({hd, 16'h0}));
      if (z > 64'sh40000000) begin
        z -= 64'sh80000000;
        flip = 1;
      end else if (z < -64'sh40000000) begin
        z += 64'sh80000000;
        flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          t = cx - (cy >>> i);
          cy += cx >>> i;
          z -= ARC_TAB[i];
        end else begin
          t = cx + (cy >>> i);
          cy -= cx >>> i;
          z += ARC_TAB[i];
        end
        cx = t;
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      g = nearest_point(x + ((longint'(reg_lookahead) * cx) >>> 30),
                        y + ((longint'(reg_lookahead) * cy) >>> 30));
      v = longint'(trk_speed[nearest_point(x, y)]);
      dx = clamp_offset(longint'(trk_x[g]) - x);
      dy = clamp_offset(longint'(trk_y[g]) - y);
      side = (dx * (cy >>> 6) - dy * (cx >>> 6)) >>> 24;
      d2 = 64'(dx * dx + dy * dy);
      k = side * longint'(reg_track);
      if (d2 == 0) begin
        d2 = 1;
        k = 0;
      end
      nl = longint'(d2) + k;
      nr = longint'(d2) - k;
      m = magnitude(nl) > magnitude(nr) ? magnitude(nl) : magnitude(nr);
      flip = wide(magnitude(v)) * wide(m) > wide(reg_speed_lim) * wide(d2);
      r.left = 16'(wheel_drive(v, nl, d2, m, flip));
      r.right = 16'(wheel_drive(v, nr, d2, m, flip));
      r.arrived = dist_sq(x - trk_end_x, y - trk_end_y) < wide(reg_tolerance) * wide(reg_tolerance);
    end
    expected_drives = {expected_drives, r};
  endtask

  // Raises start with a payload and holds it until the request is taken.
  task automatic send_request(logic op, logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [15:0] spd, logic [15:0] hd, logic fin);
    start_i <= 1'b1;
    op_i <= op;
    coord_x_i <= x;
    coord_y_i <= y;
    point_speed_i <= spd;
    heading_angle_i <= hd;
    final_point_i <= fin;
    do @(posedge clk_i); while (busy_o);
    track_request(op, x, y, spd, hd, fin);
  endtask

  task automatic sender_gap();
    int gap;
    if (no_idle) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ppt_pkg::CFG_LOOKAHEAD: reg_lookahead = 64'(data);
      ppt_pkg::CFG_TOLERANCE: reg_tolerance = 64'(data);
      ppt_pkg::CFG_SPEED_LIM: reg_speed_lim = 64'(data[14:0]);
      default:                reg_track = 64'(data);
    endcase
  endtask

  task automatic set_regs(logic [23:0] look, logic [23:0] tol, logic [23:0] lim,
                          logic [23:0] track);
    drain();
    write_reg(ppt_pkg::CFG_LOOKAHEAD, look);
    write_reg(ppt_pkg::CFG_TOLERANCE, tol);
    write_reg(ppt_pkg::CFG_SPEED_LIM, lim);
    write_reg(ppt_pkg::CFG_TRACK, track);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_empty_path();
    send_request(ppt_pkg::OP_POSE, 32'sh80000000, 32'sh7FFFFFFF, 16'sh7FFF, 16'h0000, 1'b1);
    send_request(ppt_pkg::OP_POSE, 32'sh7FFFFFFF, 32'sh80000000, 16'sh8000, 16'hFFFF, 1'b0);
  endtask

  task automatic test_path_load();
    set_regs(24'd786432, 24'd131072, 24'd127, 24'd786432);
    send_request(ppt_pkg::OP_LOAD, 32'sd0, 32'sd0, 16'sh7FFF, 16'hFFFF, 1'b0);
    send_request(ppt_pkg::OP_LOAD, 32'sd1048576, 32'sd0, 16'sh8000, 16'h0000, 1'b0);
    send_request(ppt_pkg::OP_LOAD, 32'sd2097152, 32'sd262144, 16'sd100, 16'h1234, 1'b1);
    send_request(ppt_pkg::OP_LOAD, 32'sh7FFFFFFF, 32'sh80000000, -16'sd5, 16'h0, 1'b0);
  endtask

  task automatic test_pose_cases();
    logic [15:0] headings [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
    foreach (headings[i])
      send_request(ppt_pkg::OP_POSE, 32'sd1048576, 32'sd65536, 16'sh7FFF, headings[i], 1'b1);
    // Robot sitting on the final point counts as arrived.
    send_request(ppt_pkg::OP_POSE, 32'sd2097152, 32'sd262144, 16'sd0, 16'h6000, 1'b0);
    // Offsets to the goal saturate when the robot is far away.
    send_request(ppt_pkg::OP_POSE, 32'sh80000000, 32'sh7FFFFFFF, 16'sd0, 16'hE000, 1'b0);
    // No lookahead: the goal can coincide with the robot.
    set_regs(24'd0, 24'hFFFFFF, 24'd32767, 24'hFFFFFF);
    send_request(ppt_pkg::OP_POSE, 32'sd0, 32'sd0, 16'sd0, 16'h0000, 1'b0);
    send_request(ppt_pkg::OP_POSE, 32'sd300000, 32'sd100000, 16'sd0, 16'hA000, 1'b0);
    // A zero speed limit stops both wheels.
    set_regs(24'hFFFFFF, 24'd0, 24'd0, 24'd0);
    send_request(ppt_pkg::OP_POSE, 32'sd500000, -32'sd400000, 16'sd0, 16'h3000, 1'b0);
    set_regs(24'd65536, 24'd1, 24'd1, 24'd786432);
    send_request(ppt_pkg::OP_POSE, 32'sd1048576, -32'sd65536, 16'sd0, 16'h9000, 1'b0);
  endtask

  task automatic test_random();
    logic signed [31:0] x, y;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 35 == 0) begin
        set_regs(24'($urandom_range(0, 24'h1FFFFF)), 24'($urandom_range(0, 24'h3FFFFF)),
                 24'($urandom_range(1, 32767)), 24'($urandom_range(0, 24'hFFFFFF)));
        no_idle = (n == 70);
      end
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom;
        y = $urandom;
      end else begin
        x = $signed($urandom_range(0, 24'h7FFFFF)) - 32'sh400000;
        y = $signed($urandom_range(0, 24'h7FFFFF)) - 32'sh400000;
      end
      if ($urandom_range(0, 99) < 45) begin
        send_request(ppt_pkg::OP_LOAD, x, y, 16'($urandom), 16'($urandom),
                     $urandom_range(0, 99) < 8);
      end else begin
        if ($urandom_range(0, 6) == 0) begin
          x = 32'(trk_end_x) + $signed($urandom_range(0, 8191)) - 32'sd4096;
          y = 32'(trk_end_y) + $signed($urandom_range(0, 8191)) - 32'sd4096;
        end
        send_request(ppt_pkg::OP_POSE, x, y, 16'($urandom), 16'($urandom), 1'($urandom));
      end
      sender_gap();
    end
  endtask

  task automatic test_store_full();
    set_regs(24'd786432, 24'd131072, 24'd127, 24'd786432);
    // A final point equal to the previous one extends until the store is full.
    send_request(ppt_pkg::OP_LOAD, 32'sd65536, 32'sd65536, 16'sd50, 16'h0, 1'b0);
    send_request(ppt_pkg::OP_LOAD, 32'sd65536, 32'sd65536, 16'sd60, 16'h0, 1'b1);
    send_request(ppt_pkg::OP_LOAD, 32'sd1, 32'sd2, 16'sd70, 16'h0, 1'b0);
    send_request(ppt_pkg::OP_LOAD, 32'sd3, 32'sd4, 16'sd80, 16'h0, 1'b1);
    send_request(ppt_pkg::OP_POSE, 32'sd70000, 32'sd60000, 16'sd0, 16'h1000, 1'b0);
  endtask

  always @(posedge clk_i) begin
    drive_result_t e;
    if (rst_ni && done_o) begin
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: left %0d right %0d status %0d",
                                       left_drive_o, right_drive_o, status_o);
      end else begin
        e = expected_drives.pop_front();
        if (left_drive_o !== e.left || right_drive_o !== e.right ||
            arrived_o !== e.arrived || status_o !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     e.left, e.right, e.arrived, e.status,
                     left_drive_o, right_drive_o, arrived_o, status_o);
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("pure_pursuit_path_tracker_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_path();
    test_path_load();
    test_pose_cases();
    test_random();
    test_store_full();
    drain();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) $display("pure_pursuit_path_tracker_test: clean");
    else $display("pure_pursuit_path_tracker_test: errors");
    $finish;
  end

endmodule

/* sim.f */
rtl/ppt_pkg.sv
rtl/ppt_path_mem.sv
rtl/ppt_div.sv
rtl/pure_pursuit_path_tracker.sv
rtl/ppt_checker.sv
dv/pure_pursuit_path_tracker_test.sv
